FILE: src/afsk_fm_modulator_assert.svh
// ----------------------------------------------------------------------------
// afsk_fm_modulator_assert.svh
// Assertion macros used by the modulator RTL.
// ----------------------------------------------------------------------------
`ifndef AFSK_FM_MODULATOR_ASSERT_SVH
`define AFSK_FM_MODULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AFSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AFSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/afskfm_pkg.sv
// ----------------------------------------------------------------------------
// afskfm_pkg
// Types, register indexes and the sine table for the AFSK FM modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package afskfm_pkg;

    // Operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SAMPLES_PER_BIT = 3'd0;
    localparam t_cfg_idx CFG_MARK_STEP       = 3'd1;
    localparam t_cfg_idx CFG_SPACE_STEP      = 3'd2;
    localparam t_cfg_idx CFG_REPEAT_TOTAL    = 3'd3;
    localparam t_cfg_idx CFG_FM_DEVIATION    = 3'd4;
    localparam t_cfg_idx CFG_SYMBOL_BITS     = 3'd5;

    // Phase word: top byte indexes the sine table
    localparam int         PHASE_SHIFT = 24;
    localparam logic [7:0] QTR_IDX     = 8'd64;

    // Per-sample status carried down the sample pipeline
    typedef struct packed {
        logic       act;
        logic       ev;
        logic [7:0] cnt;
        logic       done;
    } t_evt;

    // First quadrant of the sine, 0..64 inclusive
    localparam logic [6:0] QSINE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // Full-turn signed sine from an 8-bit phase index
    function automatic logic signed [7:0] sine8(input logic [7:0] idx);
        logic [6:0]        ri;
        logic signed [7:0] v;
        ri = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
        v  = $signed({1'b0, QSINE[ri]});
        return idx[7] ? -v : v;
    endfunction

endpackage

`default_nettype wire

FILE: src/afskfm_ram.sv
// ----------------------------------------------------------------------------
// afskfm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module afskfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/afsk_fm_modulator.sv
// ----------------------------------------------------------------------------
// afsk_fm_modulator
// AFSK tone generator feeding an FM carrier, with the message held in a word
// memory. Each tick transaction yields one baseband I/Q sample.
//
//   channel  direction  handshake                   payload
//   in       to block   i_in_valid / o_in_stall     operation, word_addr, word_data
//   out      from block o_out_valid / i_out_stall   active, i/q_sample, progress, done
//   cfg      to block   i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One input transaction per clock while o_in_stall is low. A tick result passes
// through the six-register sample pipeline, whose last register is the output register.
// The input stalls while the sample pipeline is full behind a stalled output,
// and for one cycle when two word fetches fall on consecutive ticks
// (samples_per_bit of zero), while the registered word memory read is in flight.
// Reset is synchronous, active low; the word memory is not cleared.
// WORD_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

`include "afsk_fm_modulator_assert.svh"

module afsk_fm_modulator #(
    parameter int WORD_DEPTH = 512,
    parameter int WORD_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_operation,
    input  wire logic [8:0]             i_word_addr,
    input  wire logic [15:0]            i_word_data,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_active,
    output logic signed [7:0]           o_i_sample,
    output logic signed [7:0]           o_q_sample,
    output logic                        o_progress_event,
    output logic [7:0]                  o_progress_count,
    output logic                        o_done_res,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire afskfm_pkg::t_cfg_idx   i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);

    import afskfm_pkg::*;

    localparam int         AW     = $clog2(WORD_DEPTH);
    localparam int         BW     = $clog2(WORD_BITS);
    localparam logic [5:0] WB_MAX = 6'(WORD_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_spb;
    logic [31:0] r_mark;
    logic [31:0] r_space;
    logic [7:0]  r_rpt;
    logic [31:0] r_dev;
    logic [4:0]  r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb   <= 16'd1;
            r_mark  <= '0;
            r_space <= '0;
            r_rpt   <= 8'd1;
            r_dev   <= '0;
            r_sb    <= 5'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLES_PER_BIT: r_spb   <= i_cfg_data[15:0];
                CFG_MARK_STEP:       r_mark  <= i_cfg_data;
                CFG_SPACE_STEP:      r_space <= i_cfg_data;
                CFG_REPEAT_TOTAL:    r_rpt   <= i_cfg_data[7:0];
                CFG_FM_DEVIATION:    r_dev   <= i_cfg_data;
                CFG_SYMBOL_BITS:     r_sb    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    // sequencer state
    logic          r_armed, n_armed;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [BW-1:0] r_bi, n_bi;
    logic [15:0]   r_cnt, n_cnt;
    logic [7:0]    r_rep, n_rep;
    logic          r_bit, n_bit;

    // prefetched word at the read pointer, and a copy of entry zero
    logic [WORD_BITS-1:0] r_pf, n_pf;
    logic [AW-1:0]        r_pf_addr, n_pf_addr;
    logic                 r_pf_pend, n_pf_pend;
    logic [WORD_BITS-1:0] r_w0;

    // sample pipeline
    logic        r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_out_vld;
    t_evt        r_s1_evt, r_s2_evt, r_s3_evt, r_s4_evt, r_s5_evt, r_out_evt;
    logic [31:0] r_s1_step;
    logic [7:0]  r_s2_tidx;
    logic signed [7:0] r_s3_ts;
    logic [31:0] r_s4_delta;
    logic [7:0]  r_s5_cidx;
    logic signed [7:0] r_out_i, r_out_q;
    logic [31:0] r_tone, r_car;

    logic w_mv_out, w_free5, w_free4, w_free3, w_free2, w_free1;
    t_op  w_op;
    logic w_acc, w_wr, w_start, w_stop, w_tick;
    logic w_fetch, w_hazard, w_issue;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_rdata;
    logic [5:0]           w_sb_eff;
    logic [BW-1:0]        w_sc, w_bi;
    logic [AW-1:0]        w_ptr;
    logic                 w_zero, w_more, w_wrap, w_end, w_last, w_bitv;
    logic [WORD_BITS-1:0] w_word, w_shift;
    t_evt                 w_evt;
    logic [31:0]          w_step, w_tone_sum, w_car_sum, w_ts_ext;

    // ------------------------------------------------------------------
    // Handshake and pipeline flow
    // ------------------------------------------------------------------
    assign w_mv_out = !r_out_vld || !i_out_stall;
    assign w_free5  = !r_s5_vld  || w_mv_out;
    assign w_free4  = !r_s4_vld  || w_free5;
    assign w_free3  = !r_s3_vld  || w_free4;
    assign w_free2  = !r_s2_vld  || w_free3;
    assign w_free1  = !r_s1_vld  || w_free2;

    assign w_fetch    = (r_cnt >= r_spb);
    // a fetch tick needs the prefetched word; wait out an in-flight read
    assign w_hazard   = r_pf_pend && r_armed && w_fetch;
    assign o_in_stall = !w_free1 || w_hazard;

    assign w_op    = t_op'(i_operation);
    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_wr    = w_acc && (w_op == OP_WRITE);
    assign w_start = w_acc && (w_op == OP_START);
    assign w_stop  = w_acc && (w_op == OP_STOP);
    assign w_tick  = w_acc && (w_op == OP_TICK);
    assign w_issue = w_tick && r_armed && w_fetch;

    assign w_waddr = AW'(i_word_addr);
    assign w_wdata = WORD_BITS'(i_word_data);

    // ------------------------------------------------------------------
    // Word memory
    // ------------------------------------------------------------------
    afskfm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_DEPTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_ptr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Bit fetch: symbol length, end of message, repeat, bit select
    // ------------------------------------------------------------------
    always_comb begin
        if (r_sb == 5'd0) begin
            w_sb_eff = 6'd1;
        end else if ({1'b0, r_sb} > WB_MAX) begin
            w_sb_eff = WB_MAX;
        end else begin
            w_sb_eff = {1'b0, r_sb};
        end
        w_sc    = BW'(w_sb_eff - 6'd1);
        w_zero  = (r_pf == '0);
        w_more  = (({1'b0, r_rep} + 9'd1) < {1'b0, r_rpt});
        w_wrap  = w_fetch && w_zero && w_more;
        w_end   = w_fetch && w_zero && !w_more;
        w_word  = w_wrap ? r_w0 : r_pf;
        w_bi    = w_wrap ? '0 : r_bi;
        w_ptr   = w_wrap ? '0 : r_ptr;
        w_shift = w_word >> (w_sc - w_bi);
        w_bitv  = (w_bi <= w_sc) ? w_shift[0] : 1'b0;
        w_last  = (w_bi >= w_sc);
    end

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_armed = r_armed;
        n_ptr   = r_ptr;
        n_bi    = r_bi;
        n_cnt   = r_cnt;
        n_rep   = r_rep;
        n_bit   = r_bit;
        w_evt   = '0;

        if (w_start) begin
            if (r_spb == 16'd0) begin
                n_armed = 1'b0;
            end else begin
                n_armed = 1'b1;
                n_cnt   = r_spb;
                n_rep   = '0;
                n_bi    = '0;
                n_ptr   = '0;
                n_bit   = 1'b0;
            end
        end

        if (w_stop) begin
            n_armed = 1'b0;
        end

        if (w_tick && r_armed) begin
            w_evt.act = 1'b1;
            if (w_fetch) begin
                n_bit = w_bitv;
                n_bi  = w_last ? '0 : (w_bi + BW'(1));
                n_ptr = w_last ? (w_ptr + AW'(1)) : w_ptr;
                n_cnt = '0;
                if (w_wrap) begin
                    n_rep     = r_rep + 8'd1;
                    w_evt.ev  = 1'b1;
                    w_evt.cnt = r_rep + 8'd1;
                end
                if (w_end) begin
                    n_armed    = 1'b0;
                    w_evt.ev   = 1'b1;
                    w_evt.cnt  = r_rep;
                    w_evt.done = 1'b1;
                end
            end else begin
                n_cnt = r_cnt + 16'd1;
            end
        end

        w_step = n_bit ? r_mark : r_space;
    end

    // ------------------------------------------------------------------
    // Prefetch register with write forwarding
    // ------------------------------------------------------------------
    always_comb begin
        n_pf      = r_pf;
        n_pf_addr = w_issue ? n_ptr : r_pf_addr;
        n_pf_pend = w_issue;
        if (r_pf_pend) begin
            n_pf = w_rdata;
        end
        // a newer write to the same entry wins over the read data
        if (w_wr && (w_waddr == r_pf_addr)) begin
            n_pf = w_wdata;
        end
        if (w_start) begin
            n_pf      = r_w0;
            n_pf_addr = '0;
        end
    end

    // Sequencer and prefetch control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_ptr     <= '0;
            r_bi      <= '0;
            r_cnt     <= '0;
            r_rep     <= '0;
            r_bit     <= 1'b0;
            r_pf_addr <= '0;
            r_pf_pend <= 1'b0;
        end else begin
            r_armed   <= n_armed;
            r_ptr     <= n_ptr;
            r_bi      <= n_bi;
            r_cnt     <= n_cnt;
            r_rep     <= n_rep;
            r_bit     <= n_bit;
            r_pf_addr <= n_pf_addr;
            r_pf_pend <= n_pf_pend;
        end
    end

    // Word data registers
    always_ff @(posedge i_clk) begin
        r_pf <= n_pf;
        if (w_wr && (w_waddr == '0)) begin
            r_w0 <= w_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Sample pipeline: step, tone phase, tone sine, product, carrier, I/Q
    // ------------------------------------------------------------------
    assign w_tone_sum = r_tone + r_s1_step;
    assign w_ts_ext   = {{24{r_s3_ts[7]}}, r_s3_ts};
    assign w_car_sum  = r_car + r_s4_delta;

    // Valid bits and phase accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_tone    <= '0;
            r_car     <= '0;
        end else begin
            if (w_free1) r_s1_vld  <= w_tick;
            if (w_free2) r_s2_vld  <= r_s1_vld;
            if (w_free3) r_s3_vld  <= r_s2_vld;
            if (w_free4) r_s4_vld  <= r_s3_vld;
            if (w_free5) r_s5_vld  <= r_s4_vld;
            if (w_mv_out) r_out_vld <= r_s5_vld;
            if (r_s1_vld && w_free2 && r_s1_evt.act) begin
                r_tone <= w_tone_sum;
            end
            if (r_s4_vld && w_free5 && r_s4_evt.act) begin
                r_car <= w_car_sum;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_evt  <= w_evt;
            r_s1_step <= w_step;
        end
        if (r_s1_vld && w_free2) begin
            r_s2_evt  <= r_s1_evt;
            r_s2_tidx <= w_tone_sum[PHASE_SHIFT +: 8];
        end
        if (r_s2_vld && w_free3) begin
            r_s3_evt <= r_s2_evt;
            r_s3_ts  <= sine8(r_s2_tidx);
        end
        if (r_s3_vld && w_free4) begin
            r_s4_evt   <= r_s3_evt;
            r_s4_delta <= w_ts_ext * r_dev;
        end
        if (r_s4_vld && w_free5) begin
            r_s5_evt  <= r_s4_evt;
            r_s5_cidx <= w_car_sum[PHASE_SHIFT +: 8];
        end
        if (r_s5_vld && w_mv_out) begin
            r_out_evt <= r_s5_evt;
            r_out_i   <= r_s5_evt.act ? sine8(r_s5_cidx + QTR_IDX) : 8'sd0;
            r_out_q   <= r_s5_evt.act ? sine8(r_s5_cidx) : 8'sd0;
        end
    end

    // Output ports
    assign o_out_valid      = r_out_vld;
    assign o_active         = r_out_evt.act;
    assign o_i_sample       = r_out_i;
    assign o_q_sample       = r_out_q;
    assign o_progress_event = r_out_evt.ev;
    assign o_progress_count = r_out_evt.cnt;
    assign o_done_res       = r_out_evt.done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AFSK_ASSERT_NOW(a_fetch_not_stale, i_clk, i_rst_n,
        w_tick && r_armed && w_fetch, !r_pf_pend,
        "word fetch used a prefetch still in flight")
    `AFSK_ASSERT_NEXT(a_end_disarms, i_clk, i_rst_n,
        w_tick && r_armed && w_end, !r_armed,
        "final pass ended but block still armed")
    `AFSK_ASSERT_NOW(a_done_has_event, i_clk, i_rst_n,
        o_out_valid && o_done_res, o_progress_event && o_active,
        "done without progress event on an active sample")
    `AFSK_ASSERT_NOW(a_idle_zero, i_clk, i_rst_n,
        o_out_valid && !o_active,
        (o_i_sample == 8'sd0) && (o_q_sample == 8'sd0) && !o_progress_event,
        "idle sample carries nonzero fields")

endmodule

`default_nettype wire

FILE: dv/afsk_fm_modulator_tb.sv
// ----------------------------------------------------------------------------
// afsk_fm_modulator_tb
// Self-checking testbench for the AFSK FM modulator. An internal model of
// the word store, bit sequencer, tone oscillator and carrier phase predicts
// every tick sample. Directed tests cover the register extremes and the
// corner cases of the sequencer. Randomized message traffic follows, with
// idle cycles on the input side and backpressure on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module afsk_fm_modulator_tb;

    import afskfm_pkg::*;

    // Spare register indexes: writes to them must have no effect
    localparam t_cfg_idx CFG_SPARE_6 = 3'd6;
    localparam t_cfg_idx CFG_SPARE_7 = 3'd7;

    // First quadrant of the sine, 0..64 inclusive
    localparam int QUARTER_SINE [65] = '{
        0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
        49, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
        90, 92, 94, 96, 98, 100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
        117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
        127
    };

    typedef struct packed {
        logic              act;
        logic signed [7:0] i_s;
        logic signed [7:0] q_s;
        logic              ev;
        logic [7:0]        cnt;
        logic              done;
    } iq_sample_t;

    // DUT signals
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation = 2'd0;
    logic [8:0]        i_word_addr = 9'd0;
    logic [15:0]       i_word_data = 16'd0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_active;
    logic signed [7:0] o_i_sample;
    logic signed [7:0] o_q_sample;
    logic              o_progress_event;
    logic [7:0]        o_progress_count;
    logic              o_done_res;
    logic              i_cfg_we    = 1'b0;
    t_cfg_idx          i_cfg_index = CFG_SAMPLES_PER_BIT;
    logic [31:0]       i_cfg_data  = 32'd0;

    // Model registers, at their reset values
    logic [15:0] spb_reg   = 16'd1;
    logic [31:0] mark_reg  = 32'd0;
    logic [31:0] space_reg = 32'd0;
    logic [7:0]  reps_reg  = 8'd1;
    logic [31:0] dev_reg   = 32'd0;
    logic [4:0]  sbits_reg = 5'd8;

    // Model sequencer and oscillator state
    logic [15:0] msg_store [512];
    logic [8:0]  rd_ptr      = 9'd0;
    int          bit_pos     = 0;
    logic [15:0] hold_cnt    = 16'd0;
    logic [7:0]  passes_done = 8'd0;
    logic [15:0] cur_word    = 16'd0;
    logic        cur_bit     = 1'b0;
    logic [31:0] tone_ph     = 32'd0;
    logic [31:0] carrier_ph  = 32'd0;
    logic        tx_armed    = 1'b0;

    iq_sample_t expected_iq [$];
    int         err_count  = 0;
    int         items_sent = 0;
    logic       calm       = 1'b0;   // no idling on either side while set

    afsk_fm_modulator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_word_addr      (i_word_addr),
        .i_word_data      (i_word_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_active         (o_active),
        .o_i_sample       (o_i_sample),
        .o_q_sample       (o_q_sample),
        .o_progress_event (o_progress_event),
        .o_progress_count (o_progress_count),
        .o_done_res       (o_done_res),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Full-turn signed sine from the top byte of a phase word
    function automatic logic signed [7:0] sine_lookup(input logic [7:0] idx);
        int r;
        int v;
        r = idx[5:0];
        v = idx[6] ? QUARTER_SINE[64 - r] : QUARTER_SINE[r];
        if (idx[7]) v = -v;
        return v[7:0];
    endfunction

    // Advance the model by one accepted transaction; ticks queue a sample
    task automatic modulate_step(input t_op op, input logic [8:0] addr,
                                 input logic [15:0] data);
        iq_sample_t  s;
        int          sc;
        logic signed [7:0] ts;
        logic [31:0] ts_ext;
        logic [31:0] delta;
        logic [31:0] i_ph;
        s = '0;
        case (op)
            OP_WRITE: msg_store[addr] = data;
            OP_START: begin
                if (spb_reg == 16'd0) begin
                    tx_armed = 1'b0;
                end else begin
                    hold_cnt    = spb_reg;
                    passes_done = 8'd0;
                    bit_pos     = 0;
                    rd_ptr      = 9'd0;
                    cur_word    = 16'd0;
                    cur_bit     = 1'b0;
                    tx_armed    = 1'b1;
                end
            end
            OP_STOP: tx_armed = 1'b0;
            default: begin
                if (tx_armed) begin
                    sc = sbits_reg;
                    if (sc == 0) sc = 1;
                    if (sc > 16) sc = 16;
                    sc = sc - 1;
                    // bit boundary: fetch next bit, handle end of message
                    if (hold_cnt >= spb_reg) begin
                        cur_word = msg_store[rd_ptr];
                        if (cur_word == 16'd0) begin
                            if (int'(passes_done) + 1 < int'(reps_reg)) begin
                                bit_pos     = 0;
                                rd_ptr      = 9'd0;
                                cur_word    = msg_store[0];
                                s.ev        = 1'b1;
                                s.cnt       = passes_done + 8'd1;
                                passes_done = passes_done + 8'd1;
                            end else begin
                                cur_word = 16'd0;
                                s.ev     = 1'b1;
                                s.done   = 1'b1;
                                s.cnt    = passes_done;
                                tx_armed = 1'b0;
                            end
                        end
                        cur_bit = (bit_pos <= sc) ? cur_word[sc - bit_pos] : 1'b0;
                        if (bit_pos >= sc) begin
                            bit_pos = 0;
                            rd_ptr  = rd_ptr + 9'd1;
                        end else begin
                            bit_pos = bit_pos + 1;
                        end
                        hold_cnt = 16'd0;
                    end else begin
                        hold_cnt = hold_cnt + 16'd1;
                    end
                    // tone oscillator drives the carrier phase
                    tone_ph    = tone_ph + (cur_bit ? mark_reg : space_reg);
                    ts         = sine_lookup(tone_ph[31:24]);
                    ts_ext     = {{24{ts[7]}}, ts};
                    delta      = ts_ext * dev_reg;
                    carrier_ph = carrier_ph + delta;
                    i_ph       = carrier_ph + 32'h4000_0000;
                    s.act      = 1'b1;
                    s.i_s      = sine_lookup(i_ph[31:24]);
                    s.q_s      = sine_lookup(carrier_ph[31:24]);
                end
                expected_iq.push_back(s);
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Output side: compare each accepted sample, drive random backpressure
    always @(posedge i_clk) begin
        iq_sample_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_iq.size() == 0) begin
                $display("%0t: sample with none expected (active %0d, i %0d, q %0d)",
                         $time, o_active, o_i_sample, o_q_sample);
                err_count++;
            end else begin
                want = expected_iq.pop_front();
                check_field("active", want.act, o_active);
                check_field("i_sample", want.i_s, o_i_sample);
                check_field("q_sample", want.q_s, o_q_sample);
                check_field("progress_event", want.ev, o_progress_event);
                check_field("progress_count", want.cnt, o_progress_count);
                check_field("done_res", want.done, o_done_res);
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 10);
    end

    // One input transaction, with an optional idle gap in front
    task automatic send_item(input t_op op, input logic [8:0] addr, input logic [15:0] data);
        int gap;
        gap = (!calm && $urandom_range(99) < 10) ? $urandom_range(3, 1) : 0;
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_word_addr <= addr;
        i_word_data <= data;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
        modulate_step(op, addr, data);
    endtask

    // Non-write operation with random don't-care payload
    task automatic send_op(input t_op op);
        send_item(op, 9'($urandom), 16'($urandom));
    endtask

    // Hold off input until every sample is back and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        while (expected_iq.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SAMPLES_PER_BIT: spb_reg   = data[15:0];
            CFG_MARK_STEP:       mark_reg  = data;
            CFG_SPACE_STEP:      space_reg = data;
            CFG_REPEAT_TOTAL:    reps_reg  = data[7:0];
            CFG_FM_DEVIATION:    dev_reg   = data;
            CFG_SYMBOL_BITS:     sbits_reg = data[4:0];
            default: ;
        endcase
    endtask

    // Write all registers; unused upper data bits carry noise
    task automatic program_cfg(input logic [15:0] spb, input logic [31:0] mark,
                               input logic [31:0] space, input logic [7:0] reps,
                               input logic [31:0] dev, input logic [4:0] sbits);
        settle();
        write_cfg(CFG_SAMPLES_PER_BIT, {16'($urandom), spb});
        write_cfg(CFG_MARK_STEP, mark);
        write_cfg(CFG_SPACE_STEP, space);
        write_cfg(CFG_REPEAT_TOTAL, {24'($urandom), reps});
        write_cfg(CFG_FM_DEVIATION, dev);
        write_cfg(CFG_SYMBOL_BITS, {27'($urandom), sbits});
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'hFFFF;
            1:       return 16'h0001;
            2:       return 16'h8000;
            default: return 16'($urandom_range(65535, 1));
        endcase
    endfunction

    // Message of n nonzero words at address 0, terminated by a zero word
    task automatic load_message(input int n);
        for (int k = 0; k < n; k++) send_item(OP_WRITE, 9'(k), pick_word());
        send_item(OP_WRITE, 9'(n), 16'd0);
    endtask

    // Tick until the model disarms (or stop at the cap), then a few idle ticks
    task automatic run_to_end(input int cap);
        int n;
        n = 0;
        while (tx_armed && n < cap) begin
            send_op(OP_TICK);
            n++;
        end
        if (tx_armed) send_op(OP_STOP);
        repeat (2) send_op(OP_TICK);
    endtask

    // Every store entry gets a nonzero word, so no read ever hits an unwritten one
    task automatic test_store_fill();
        for (int a = 0; a < 512; a++) send_item(OP_WRITE, 9'(a), pick_word());
    endtask

    // Ticks while idle give all-zero samples; spare register writes change nothing
    task automatic test_idle_and_spare();
        send_op(OP_STOP);
        repeat (3) send_op(OP_TICK);
        settle();
        write_cfg(CFG_SPARE_6, $urandom);
        write_cfg(CFG_SPARE_7, $urandom);
        repeat (2) send_op(OP_TICK);
    endtask

    // Store has no zero word: the read pointer runs past the last address
    task automatic test_pointer_wrap();
        program_cfg(16'd1, $urandom, $urandom, 8'd1, $urandom, 5'd1);
        calm = 1'b1;
        send_op(OP_START);
        repeat (1040) send_op(OP_TICK);
        send_op(OP_STOP);
        send_op(OP_TICK);
        calm = 1'b0;
    endtask

    task automatic test_single_pass();
        program_cfg(16'd2, 32'hFFFF_FFFF, 32'd0, 8'd2, 32'hFFFF_FFFF, 5'd8);
        load_message(3);
        send_op(OP_START);
        run_to_end(400);
    endtask

    // Start with zero bit length acts as a stop, also while transmitting
    task automatic test_start_without_length();
        program_cfg(16'd1, $urandom, $urandom, 8'd1, $urandom, 5'd8);
        load_message(2);
        send_op(OP_START);
        repeat (3) send_op(OP_TICK);
        settle();
        write_cfg(CFG_SAMPLES_PER_BIT, 32'd0);
        send_op(OP_START);
        repeat (2) send_op(OP_TICK);
        send_op(OP_START);
        send_op(OP_TICK);
    endtask

    task automatic test_longest_bit();
        program_cfg(16'hFFFF, $urandom, $urandom, 8'd1, $urandom, 5'd16);
        load_message(1);
        send_op(OP_START);
        repeat (6) send_op(OP_TICK);
        send_op(OP_STOP);
        send_op(OP_TICK);
    endtask

    // Zero width counts as one bit, widths past 16 clamp to 16
    task automatic test_symbol_bits_limits();
        logic [4:0] widths [3];
        widths = '{5'd0, 5'd31, 5'd16};
        foreach (widths[k]) begin
            program_cfg(16'd1, $urandom, $urandom, 8'd1, $urandom, widths[k]);
            load_message(2);
            send_op(OP_START);
            run_to_end(200);
        end
    endtask

    // Zero repeats sends once; 255 repeats runs the progress count up to 254
    task automatic test_repeat_limits();
        program_cfg(16'd1, $urandom, $urandom, 8'd0, $urandom, 5'd3);
        load_message(2);
        send_op(OP_START);
        run_to_end(100);
        program_cfg(16'd1, $urandom, $urandom, 8'd255, $urandom, 5'd1);
        load_message(1);
        send_op(OP_START);
        run_to_end(600);
    endtask

    // Symbol width shrinks mid-word: bit index lands past the symbol
    task automatic test_symbol_shrink();
        program_cfg(16'd1, $urandom, $urandom, 8'd1, $urandom, 5'd16);
        load_message(2);
        send_op(OP_START);
        repeat (12) send_op(OP_TICK);
        settle();
        write_cfg(CFG_SYMBOL_BITS, 32'd2);
        run_to_end(100);
    endtask

    // Stop mid-message, idle, then restart; phases carry over
    task automatic test_stop_restart();
        program_cfg(16'd2, $urandom, $urandom, 8'd3, $urandom, 5'd4);
        load_message(2);
        send_op(OP_START);
        repeat (5) send_op(OP_TICK);
        send_op(OP_STOP);
        repeat (2) send_op(OP_TICK);
        send_op(OP_START);
        run_to_end(300);
    endtask

    // Mostly complete messages under random settings, with some noise mixed in
    task automatic test_random_traffic();
        int          stop_at;
        int          n;
        int          r;
        logic [15:0] spb;
        logic [31:0] steps [3];
        logic [7:0]  reps;
        logic [4:0]  sbits;
        stop_at = items_sent + 700;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 7) begin
                r = $urandom_range(99);
                spb = (r < 5) ? 16'd0 : (r < 75) ? 16'($urandom_range(3, 1))
                                                 : 16'($urandom_range(12, 4));
                foreach (steps[k]) begin
                    r = $urandom_range(99);
                    steps[k] = (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
                end
                r = $urandom_range(99);
                reps = (r < 10) ? 8'd0 : (r < 80) ? 8'($urandom_range(3, 1))
                                                  : 8'($urandom_range(8, 4));
                r = $urandom_range(99);
                sbits = (r < 10) ? 5'd0 : (r < 20) ? 5'($urandom_range(31, 17)) :
                        (r < 70) ? 5'($urandom_range(4, 1)) : 5'($urandom_range(16, 5));
                program_cfg(spb, steps[0], steps[1], reps, steps[2], sbits);
            end
            if ($urandom_range(9) < 8) load_message($urandom_range(3, 1));
            send_op(OP_START);
            n = 0;
            while (tx_armed && n < 100) begin
                if ($urandom_range(99) < 4)
                    send_item(t_op'($urandom_range(2)), 9'($urandom), 16'($urandom));
                else
                    send_op(OP_TICK);
                n++;
            end
            if (tx_armed) send_op(OP_STOP);
            send_op(OP_TICK);
        end
    endtask

    // Reset, then the test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_fill();
        test_idle_and_spare();
        test_pointer_wrap();
        test_single_pass();
        test_start_without_length();
        test_longest_bit();
        test_symbol_bits_limits();
        test_repeat_limits();
        test_symbol_shrink();
        test_stop_restart();
        test_random_traffic();
        settle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/afskfm_pkg.sv
src/afskfm_ram.sv
src/afsk_fm_modulator.sv
dv/afsk_fm_modulator_tb.sv
